[src/u16u8_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package u16u8_pkg;

    localparam logic [1:0] ERR_NONE      = 2'd0;
    localparam logic [1:0] ERR_LONE_LOW  = 2'd1;
    localparam logic [1:0] ERR_UNPAIRED  = 2'd2;
    localparam logic [1:0] ERR_ODD_LEN   = 2'd3;

    typedef logic [7:0] t_byte;

    // One decoded code point or fault, as a run of one to four output bytes.
    typedef struct packed {
        t_byte [3:0] bytes;      // bytes[0] goes out first
        logic  [1:0] last_idx;   // index of the final byte of the run
        logic        eos;
        logic  [1:0] err;
    } t_job;

endpackage
`default_nettype wire

[src/u16u8_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface u16u8_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface
`default_nettype wire

[src/u16u8_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface u16u8_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_string;
    logic [1:0] error_kind;

    modport source (output valid, output out_byte, output end_of_string,
                    output error_kind, input ready);
    modport sink   (input valid, input out_byte, input end_of_string,
                    input error_kind, output ready);
endinterface
`default_nettype wire

[src/u16u8_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    u16u8_in_if.sink  i_in,
    input  wire logic i_q_full,
    output logic      o_push,
    output t_job      o_job
);

    logic       r_phase, n_phase;
    t_byte      r_high, n_high;
    logic       r_pend, n_pend;
    logic [9:0] r_pend_bits, n_pend_bits;
    logic       r_discard, n_discard;

    logic        accept;
    logic [15:0] unit;
    logic        is_high_sur;
    logic        is_low_sur;
    logic        last;
    logic [20:0] pair_cp;

    function automatic t_job encode(input logic [20:0] cp, input logic eos);
        t_job j;
        j.bytes = '0;
        j.eos   = eos;
        j.err   = ERR_NONE;
        if (cp < 21'h80) begin
            j.bytes[0] = {1'b0, cp[6:0]};
            j.last_idx = 2'd0;
        end else if (cp < 21'h800) begin
            j.bytes[0] = {3'b110, cp[10:6]};
            j.bytes[1] = {2'b10, cp[5:0]};
            j.last_idx = 2'd1;
        end else if (cp < 21'h10000) begin
            j.bytes[0] = {4'b1110, cp[15:12]};
            j.bytes[1] = {2'b10, cp[11:6]};
            j.bytes[2] = {2'b10, cp[5:0]};
            j.last_idx = 2'd2;
        end else begin
            j.bytes[0] = {5'b11110, cp[20:18]};
            j.bytes[1] = {2'b10, cp[17:12]};
            j.bytes[2] = {2'b10, cp[11:6]};
            j.bytes[3] = {2'b10, cp[5:0]};
            j.last_idx = 2'd3;
        end
        return j;
    endfunction

    function automatic t_job fault(input logic [1:0] kind);
        t_job j;
        j.bytes    = '0;
        j.last_idx = 2'd0;
        j.eos      = 1'b1;
        j.err      = kind;
        return j;
    endfunction

    assign i_in.ready  = !i_q_full;
    assign accept      = i_in.valid && !i_q_full;
    assign last        = i_in.last_byte;
    assign unit        = {r_high, i_in.in_byte};
    assign is_high_sur = (unit[15:10] == 6'b110110);
    assign is_low_sur  = (unit[15:10] == 6'b110111);
    // 0x10000 + (high bits << 10) + low bits
    assign pair_cp     = {11'({1'b0, r_pend_bits} + 11'h40), unit[9:0]};

    always_comb begin
        n_phase     = r_phase;
        n_high      = r_high;
        n_pend      = r_pend;
        n_pend_bits = r_pend_bits;
        n_discard   = r_discard;
        o_push      = 1'b0;
        o_job       = fault(ERR_NONE);
        if (accept) begin
            if (r_discard) begin
                if (last) begin
                    n_discard = 1'b0;
                end
            end else if (!r_phase) begin
                if (last) begin
                    o_push      = 1'b1;
                    o_job       = fault(ERR_ODD_LEN);
                    n_pend      = 1'b0;
                    n_pend_bits = '0;
                end else begin
                    n_high  = i_in.in_byte;
                    n_phase = 1'b1;
                end
            end else begin
                n_phase = 1'b0;
                n_high  = '0;
                if (r_pend) begin
                    o_push      = 1'b1;
                    n_pend      = 1'b0;
                    n_pend_bits = '0;
                    if (!is_low_sur) begin
                        o_job     = fault(ERR_UNPAIRED);
                        n_discard = !last;
                    end else begin
                        o_job = encode(pair_cp, last);
                    end
                end else if (is_high_sur) begin
                    if (last) begin
                        o_push = 1'b1;
                        o_job  = fault(ERR_UNPAIRED);
                    end else begin
                        n_pend      = 1'b1;
                        n_pend_bits = unit[9:0];
                    end
                end else if (is_low_sur) begin
                    o_push    = 1'b1;
                    o_job     = fault(ERR_LONE_LOW);
                    n_discard = !last;
                end else begin
                    o_push = 1'b1;
                    o_job  = encode({5'd0, unit}, last);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_high      <= '0;
            r_pend      <= 1'b0;
            r_pend_bits <= '0;
            r_discard   <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_high      <= n_high;
            r_pend      <= n_pend;
            r_pend_bits <= n_pend_bits;
            r_discard   <= n_discard;
        end
    end

endmodule
`default_nettype wire

[src/u16u8_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module u16u8_queue
    import u16u8_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

[src/u16u8_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_job_valid,
    input  wire t_job   i_job,
    output logic        o_pop,
    u16u8_out_if.source o_out
);

    t_job       r_job;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_byte      r_out_byte;
    logic       r_out_eos;
    logic [1:0] r_out_err;

    logic out_free;
    logic at_last;
    logic done_cur;

    assign out_free = !r_out_valid || o_out.ready;
    assign at_last  = (r_idx == r_job.last_idx);
    assign done_cur = r_busy && out_free && at_last;
    // Load the next run as the current one hands over its final byte.
    assign o_pop    = i_job_valid && (!r_busy || done_cur);

    assign o_out.valid         = r_out_valid;
    assign o_out.out_byte      = r_out_byte;
    assign o_out.end_of_string = r_out_eos;
    assign o_out.error_kind    = r_out_err;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_busy && out_free) begin
            r_out_byte <= r_job.bytes[r_idx];
            r_out_eos  <= r_job.eos && at_last;
            r_out_err  <= r_job.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (done_cur) begin
                r_busy <= 1'b0;
            end else if (r_busy && out_free) begin
                r_idx <= r_idx + 2'd1;
            end
            if (r_busy && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

[src/utf16be_to_utf8_transcoder_core.sv]
// Path: a code point is queued, loaded as the current run, then its bytes leave a register.
// Throughput: one input beat per cycle while the 2-entry run queue has room; one output
// beat per cycle while the sink is ready, so output may reach 1.5 bytes per input byte
// (a unit from 0x0800 up gives 3 bytes for 2 input bytes).
// Reset: synchronous, active low; clears decoder state, queue and output valid.
`timescale 1ns / 1ps
`default_nettype none
module utf16be_to_utf8_transcoder_core
    import u16u8_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    u16u8_in_if.sink    i_in,
    u16u8_out_if.source o_out
);

    logic q_full;
    logic push;
    t_job push_job;
    logic q_valid;
    t_job q_job;
    logic pop;

    u16u8_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (push_job)
    );

    u16u8_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    u16u8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
